>>> rtl/core/rcd_pkg.sv
// rcd_pkg: shared types and constants of the rod-cutting solver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rcd_pkg;

	// fixed field widths of the stream ports
	localparam int REV_W   = 22;
	localparam int PIECE_W = 7;
	localparam int IDX_W   = 7;
	localparam int PVAL_W  = 16;
	localparam int RLEN_W  = 7;

	// revenue saturates at the top of its field
	localparam logic [REV_W-1:0] REV_MAX = '1;

	// input beat kind, carried on tuser
	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_SOLVE = 1'b1
	} cmd_t;

	// solver sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_GAP,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} state_t;

	// one result beat from solver to output stage
	typedef struct packed {
		logic [REV_W-1:0]   max_revenue;
		logic [PIECE_W-1:0] piece_length;
		logic               last_piece;
	} rcd_beat_t;

endpackage

>>> rtl/core/rcd_price_mem.sv
// rcd_price_mem: price table, one synchronous read port, one write port.
// Clears itself after reset with a sweep; uses rcd_pkg.
`timescale 1ns / 1ps

module rcd_price_mem import rcd_pkg::*; #(
	parameter int MAX_LEN = 64,
	parameter int PRICE_BITS = 16,
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  logic [PRICE_BITS-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     rd_addr,
	output logic [PRICE_BITS-1:0] rd_data,
	output logic                  clr_busy
);

	logic [PRICE_BITS-1:0] mem [MAX_LEN];
	logic [ADDR_W-1:0]     clr_addr_q;
	logic                  clr_busy_q;

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(MAX_LEN - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_addr_q] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	assign clr_busy = clr_busy_q;

endmodule

>>> rtl/core/rcd_dp_mem.sv
// rcd_dp_mem: best-revenue / first-cut table, one entry per rod length.
// Synchronous read with enable, one write port; uses rcd_pkg.
`timescale 1ns / 1ps

module rcd_dp_mem import rcd_pkg::*; #(
	parameter int MAX_LEN = 64,
	localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [LEN_W-1:0] wr_addr,
	input  logic [REV_W-1:0] wr_rev,
	input  logic [LEN_W-1:0] wr_cut,
	input  logic             rd_en,
	input  logic [LEN_W-1:0] rd_addr,
	output logic [REV_W-1:0] rd_rev,
	output logic [LEN_W-1:0] rd_cut
);

	logic [REV_W+LEN_W-1:0] mem [MAX_LEN + 1];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {wr_rev, wr_cut};
		if (rd_en)
			{rd_rev, rd_cut} <= mem[rd_addr];
	end

endmodule

>>> rtl/core/rcd_solver.sv
// rcd_solver: sequencer and compare datapath of the bottom-up fill and
// the decomposition walk. Drives both tables; uses rcd_pkg.
`timescale 1ns / 1ps

module rcd_solver import rcd_pkg::*; #(
	parameter int MAX_LEN = 64,
	parameter int PRICE_BITS = 16,
	localparam int LEN_W = $clog2(MAX_LEN + 1),
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [LEN_W-1:0]      start_n,
	output logic                  idle,
	output logic                  price_rd_en,
	output logic [ADDR_W-1:0]     price_rd_addr,
	input  logic [PRICE_BITS-1:0] price_rd_data,
	output logic                  dp_wr_en,
	output logic [LEN_W-1:0]      dp_wr_addr,
	output logic [REV_W-1:0]      dp_wr_rev,
	output logic [LEN_W-1:0]      dp_wr_cut,
	output logic                  dp_rd_en,
	output logic [LEN_W-1:0]      dp_rd_addr,
	input  logic [REV_W-1:0]      dp_rd_rev,
	input  logic [LEN_W-1:0]      dp_rd_cut,
	output logic                  beat_valid,
	input  logic                  beat_ready,
	output rcd_beat_t             beat
);

	localparam int SUM_W = ((PRICE_BITS > REV_W) ? PRICE_BITS : REV_W) + 1;

	state_t state_q, state_d;

	logic [LEN_W-1:0] j_q, i_q, n_q, rest_q;
	logic             fill_done_q;
	logic             vld_s1, first_s1, last_s1;
	logic [LEN_W-1:0] cut_s1, j_s1;
	logic [REV_W-1:0] best_q, rev_q;
	logic [LEN_W-1:0] cut_q;

	logic [SUM_W-1:0] sum;
	logic [REV_W-1:0] cand, best_nx;
	logic [LEN_W-1:0] cut_nx, piece, rest_nx;
	logic             sel;

	// candidate price[i] + r[j-i], saturated; ties keep the earlier cut
	always_comb begin
		sum     = SUM_W'(price_rd_data) + SUM_W'(dp_rd_rev);
		cand    = (sum > SUM_W'(REV_MAX)) ? REV_MAX : REV_W'(sum);
		sel     = first_s1 || (cand > best_q);
		best_nx = sel ? cand : best_q;
		cut_nx  = sel ? cut_s1 : cut_q;
	end

	// decomposition step
	always_comb begin
		piece   = ((dp_rd_cut == '0) || (dp_rd_cut > rest_q)) ? rest_q : dp_rd_cut;
		rest_nx = rest_q - piece;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = (start_n == '0) ? ST_EMIT_RD : ST_FILL;
			end
			ST_FILL: begin
				if (i_q == j_q)
					state_d = ST_GAP;
			end
			ST_GAP: begin
				state_d = fill_done_q ? ST_EMIT_RD : ST_FILL;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (beat_ready)
					state_d = (rest_nx == '0) ? ST_IDLE : ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		idle          = (state_q == ST_IDLE);
		price_rd_en   = (state_q == ST_FILL);
		price_rd_addr = ADDR_W'(i_q - 1'b1);
		dp_rd_en      = (state_q == ST_FILL) || (state_q == ST_EMIT_RD);
		dp_rd_addr    = (state_q == ST_EMIT_RD) ? rest_q : (j_q - i_q);
		if (idle && start) begin
			// r[0] = 0
			dp_wr_en   = 1'b1;
			dp_wr_addr = '0;
			dp_wr_rev  = '0;
			dp_wr_cut  = '0;
		end else begin
			dp_wr_en   = vld_s1 && last_s1;
			dp_wr_addr = j_s1;
			dp_wr_rev  = best_nx;
			dp_wr_cut  = cut_nx;
		end
		beat_valid        = (state_q == ST_EMIT_WAIT);
		beat.max_revenue  = rev_q;
		beat.piece_length = PIECE_W'(piece);
		beat.last_piece   = (rest_nx == '0);
	end

	// loop counters and read pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			i_q         <= '0;
			n_q         <= '0;
			rest_q      <= '0;
			fill_done_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_FILL);
			if (idle && start) begin
				j_q         <= LEN_W'(1);
				i_q         <= LEN_W'(1);
				n_q         <= start_n;
				rest_q      <= start_n;
				fill_done_q <= 1'b0;
			end else if (state_q == ST_FILL) begin
				if (i_q == j_q) begin
					i_q         <= LEN_W'(1);
					j_q         <= j_q + 1'b1;
					fill_done_q <= (j_q == n_q);
				end else begin
					i_q <= i_q + 1'b1;
				end
			end else if ((state_q == ST_EMIT_WAIT) && beat_ready) begin
				rest_q <= rest_nx;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		first_s1 <= (i_q == LEN_W'(1));
		last_s1  <= (i_q == j_q);
		cut_s1   <= i_q;
		j_s1     <= j_q;
		if (vld_s1) begin
			best_q <= best_nx;
			cut_q  <= cut_nx;
		end
		if (idle && start)
			rev_q <= '0;
		else if (vld_s1 && last_s1 && (j_s1 == n_q))
			rev_q <= best_nx;
	end

endmodule

>>> rtl/core/rod_cutting_dp.sv
// rod_cutting_dp: top level of the bottom-up rod-cutting solver.
// Depends on rcd_pkg, rcd_price_mem, rcd_dp_mem and rcd_solver.
`timescale 1ns / 1ps

// Rod-cutting solver. An input beat with tuser = 0 (load) writes the price
// of one rod length (1..MAX_LEN) into the price table; other indexes are
// dropped. A beat with tuser = 1 (solve) gives a rod length n, clamped to
// MAX_LEN. The block fills r[0..n] bottom-up, r[j] = max over i of
// price[i] + r[j-i] with the smallest cut kept on a tie, then walks the
// cut table and sends one output beat per piece, every beat carrying the
// best revenue; tlast marks the final piece. n = 0 gives one beat with
// revenue 0 and piece 0. Both tables live in single-port-read synchronous
// RAMs; the fill reads one (price, r) pair per cycle and adds an idle gap
// state after each length so a freshly written r[j] is read back safely.
// The run time of a solve is set by the single read port of the revenue
// table, plus any output back-pressure. Input is taken one beat at a time,
// only when the solver is idle. After reset the price table is cleared by
// a sweep over its MAX_LEN entries, during which s_tready stays low.
module rod_cutting_dp import rcd_pkg::*; #(
	parameter int MAX_LEN = 64,
	parameter int PRICE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // price_index[6:0], price_value[22:7], rod_length[29:23]
	input  logic        s_tuser,  // command (0 load, 1 solve)
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // max_revenue[21:0], piece_length[28:22]
	output logic        m_tlast   // last_piece
);

	localparam int LEN_W  = $clog2(MAX_LEN + 1);
	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CMP_W  = (LEN_W > IDX_W) ? LEN_W : IDX_W;

	logic [IDX_W-1:0]  price_index;
	logic [PVAL_W-1:0] price_value;
	logic [RLEN_W-1:0] rod_length;
	logic [CMP_W-1:0]  idx_ext, len_ext;
	logic              in_beat, idx_ok;

	logic                  load_we;
	logic [ADDR_W-1:0]     load_addr;
	logic                  solve_go;
	logic [LEN_W-1:0]      solve_n;
	logic                  clr_busy, solver_idle;

	logic                  price_rd_en;
	logic [ADDR_W-1:0]     price_rd_addr;
	logic [PRICE_BITS-1:0] price_rd_data;
	logic                  dp_wr_en, dp_rd_en;
	logic [LEN_W-1:0]      dp_wr_addr, dp_wr_cut, dp_rd_addr, dp_rd_cut;
	logic [REV_W-1:0]      dp_wr_rev, dp_rd_rev;

	logic      beat_valid, beat_ready;
	rcd_beat_t beat;
	logic      out_vld_q;
	rcd_beat_t out_q;

	// input decode
	always_comb begin
		price_index = s_tdata[IDX_W-1:0];
		price_value = s_tdata[IDX_W+PVAL_W-1:IDX_W];
		rod_length  = s_tdata[IDX_W+PVAL_W+RLEN_W-1:IDX_W+PVAL_W];
		idx_ext     = CMP_W'(price_index);
		len_ext     = CMP_W'(rod_length);
		s_tready    = solver_idle && !clr_busy;
		in_beat     = s_tvalid && s_tready;
		idx_ok      = (idx_ext != '0) && (idx_ext <= CMP_W'(MAX_LEN));
		load_we     = in_beat && (cmd_t'(s_tuser) == CMD_LOAD) && idx_ok;
		load_addr   = ADDR_W'(idx_ext - 1'b1);
		solve_go    = in_beat && (cmd_t'(s_tuser) == CMD_SOLVE);
		solve_n     = (len_ext > CMP_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : LEN_W'(len_ext);
	end

	rcd_price_mem #(
		.MAX_LEN    (MAX_LEN),
		.PRICE_BITS (PRICE_BITS)
	) u_price_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (load_we),
		.wr_addr  (load_addr),
		.wr_data  (PRICE_BITS'(price_value)),
		.rd_en    (price_rd_en),
		.rd_addr  (price_rd_addr),
		.rd_data  (price_rd_data),
		.clr_busy (clr_busy)
	);

	rcd_dp_mem #(
		.MAX_LEN (MAX_LEN)
	) u_dp_mem (
		.clk     (clk),
		.wr_en   (dp_wr_en),
		.wr_addr (dp_wr_addr),
		.wr_rev  (dp_wr_rev),
		.wr_cut  (dp_wr_cut),
		.rd_en   (dp_rd_en),
		.rd_addr (dp_rd_addr),
		.rd_rev  (dp_rd_rev),
		.rd_cut  (dp_rd_cut)
	);

	rcd_solver #(
		.MAX_LEN    (MAX_LEN),
		.PRICE_BITS (PRICE_BITS)
	) u_solver (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (solve_go),
		.start_n       (solve_n),
		.idle          (solver_idle),
		.price_rd_en   (price_rd_en),
		.price_rd_addr (price_rd_addr),
		.price_rd_data (price_rd_data),
		.dp_wr_en      (dp_wr_en),
		.dp_wr_addr    (dp_wr_addr),
		.dp_wr_rev     (dp_wr_rev),
		.dp_wr_cut     (dp_wr_cut),
		.dp_rd_en      (dp_rd_en),
		.dp_rd_addr    (dp_rd_addr),
		.dp_rd_rev     (dp_rd_rev),
		.dp_rd_cut     (dp_rd_cut),
		.beat_valid    (beat_valid),
		.beat_ready    (beat_ready),
		.beat          (beat)
	);

	// output register: refills in the same cycle the held beat leaves
	assign beat_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (beat_ready)
			out_vld_q <= beat_valid;
	end

	always_ff @(posedge clk) begin
		if (beat_ready && beat_valid)
			out_q <= beat;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_q.piece_length, out_q.max_revenue};
	assign m_tlast  = out_q.last_piece;

endmodule

>>> verif/rod_cutting_dp_tb.sv
// rod_cutting_dp_tb: self-checking testbench of the rod-cutting solver.
// Drives load and solve beats, predicts every cut piece, checks the result stream.
// Depends on rcd_pkg and rod_cutting_dp.
`timescale 1ns / 1ps

module rod_cutting_dp_tb;
	import rcd_pkg::*;

	localparam int ROD_MAX     = 64;
	localparam int PRICE_W     = 16;
	localparam int STALL_PCT   = 14;
	localparam int QUIET_LIMIT = 25000;
	localparam int RANDOM_ITEMS = 110;

	// Mirrors the price table, plans the cuts of each solve and holds
	// the planned pieces until the result stream delivers them.
	class rod_scoreboard;
		logic [PRICE_W-1:0] price_mirror [1:ROD_MAX];
		rcd_beat_t          planned_pieces [$];
		int                 errors;
		int                 solves;
		int                 pieces_checked;

		function new();
			foreach (price_mirror[i])
				price_mirror[i] = '0;
			errors = 0;
			solves = 0;
			pieces_checked = 0;
		endfunction

		function void plan_cuts(logic [RLEN_W-1:0] len);
			logic [REV_W-1:0]   best [0:ROD_MAX];
			logic [PIECE_W-1:0] cut  [0:ROD_MAX];
			logic [REV_W:0]     sum;
			logic [REV_W-1:0]   cand;
			rcd_beat_t          beat;
			int                 n;
			int                 rest;
			int                 piece;
			n = (len > ROD_MAX) ? ROD_MAX : int'(len);
			best[0] = '0;
			cut[0] = '0;
			for (int j = 1; j <= n; j++) begin
				best[j] = '0;
				cut[j] = PIECE_W'(1);
				for (int i = 1; i <= j; i++) begin
					sum = {{(REV_W + 1 - PRICE_W){1'b0}}, price_mirror[i]} + {1'b0, best[j - i]};
					cand = (sum > {1'b0, REV_MAX}) ? REV_MAX : sum[REV_W-1:0];
					// strict compare keeps the smallest cut on a tie
					if (i == 1 || cand > best[j]) begin
						best[j] = cand;
						cut[j] = PIECE_W'(i);
					end
				end
			end
			if (n == 0) begin
				beat.max_revenue = '0;
				beat.piece_length = '0;
				beat.last_piece = 1'b1;
				planned_pieces.push_back(beat);
				return;
			end
			rest = n;
			while (rest > 0) begin
				piece = int'(cut[rest]);
				if (piece == 0 || piece > rest)
					piece = rest;
				rest -= piece;
				beat.max_revenue = best[n];
				beat.piece_length = PIECE_W'(piece);
				beat.last_piece = (rest == 0);
				planned_pieces.push_back(beat);
			end
		endfunction

		function void note_input(cmd_t cmd, logic [IDX_W-1:0] idx, logic [PVAL_W-1:0] val,
				logic [RLEN_W-1:0] len);
			if (cmd == CMD_LOAD) begin
				if (idx >= 1 && idx <= ROD_MAX)
					price_mirror[int'(idx)] = val;
			end else begin
				solves++;
				plan_cuts(len);
			end
		endfunction

		function void check_result(logic [REV_W-1:0] rev, logic [PIECE_W-1:0] piece, logic last);
			rcd_beat_t want;
			if (planned_pieces.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing planned: revenue %0d piece %0d last %0b",
					$time, rev, piece, last);
				return;
			end
			want = planned_pieces.pop_front();
			pieces_checked++;
			if (rev !== want.max_revenue) begin
				errors++;
				$display("%0t: max_revenue expected %0d actual %0d", $time, want.max_revenue, rev);
			end
			if (piece !== want.piece_length) begin
				errors++;
				$display("%0t: piece_length expected %0d actual %0d", $time,
					want.piece_length, piece);
			end
			if (last !== want.last_piece) begin
				errors++;
				$display("%0t: last_piece expected %0b actual %0b", $time, want.last_piece, last);
			end
		endfunction

		function int pending();
			return planned_pieces.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	rod_scoreboard sb;
	bit            stall_free;
	int            beats_sent;
	int            quiet_cycles;

	rod_cutting_dp #(
		.MAX_LEN   (ROD_MAX),
		.PRICE_BITS(PRICE_W)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random back-pressure except in the stall-free stretch
	always @(negedge clk) begin
		m_tready <= stall_free || ($urandom_range(99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[REV_W-1:0], m_tdata[REV_W +: PIECE_W], m_tlast);
	end

	// watchdog: ends the run after too many cycles without any beat
	initial begin : watchdog
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
		$display("rod_cutting_dp_tb failed");
		$finish;
	end

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_beat(cmd_t cmd, logic [IDX_W-1:0] idx, logic [PVAL_W-1:0] val,
			logic [RLEN_W-1:0] len);
		while (!stall_free && $urandom_range(99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {2'b00, len, val, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_input(cmd, idx, val, len);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic load_price(logic [IDX_W-1:0] idx, logic [PVAL_W-1:0] val);
		send_beat(CMD_LOAD, idx, val, RLEN_W'($urandom));
	endtask

	task automatic solve_rod(logic [RLEN_W-1:0] len);
		send_beat(CMD_SOLVE, IDX_W'($urandom), PVAL_W'($urandom), len);
	endtask

	// always idles the input before returning, so the next beat starts on a later edge
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() > 0);
	endtask

	function automatic logic [PVAL_W-1:0] pick_price();
		logic [PVAL_W-1:0] v;
		case ($urandom_range(3))
			0: v = PVAL_W'($urandom);
			1: v = PVAL_W'($urandom_range(24));
			2: v = $urandom_range(1) ? '1 : '0;
			default: v = PVAL_W'($urandom_range(1000));
		endcase
		return v;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		logic [IDX_W-1:0] v;
		if ($urandom_range(99) < 10)
			v = $urandom_range(1) ? '0 : IDX_W'($urandom_range(127, ROD_MAX + 1));
		else if ($urandom_range(99) < 60)
			v = IDX_W'($urandom_range(12, 1));
		else
			v = IDX_W'($urandom_range(ROD_MAX, 1));
		return v;
	endfunction

	// mostly short rods; a few long ones and a few past the clamp
	function automatic logic [RLEN_W-1:0] pick_length();
		logic [RLEN_W-1:0] v;
		case ($urandom_range(9))
			0, 1: v = RLEN_W'($urandom_range(ROD_MAX, 13));
			2: v = RLEN_W'($urandom_range(127, ROD_MAX + 1));
			default: v = RLEN_W'($urandom_range(12));
		endcase
		return v;
	endfunction

	initial begin
		int step;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		stall_free = 1'b0;
		beats_sent = 0;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty rod and all-zero prices right after reset
		solve_rod(RLEN_W'(0));
		solve_rod(RLEN_W'(5));
		// out-of-range indexes are dropped
		load_price(IDX_W'(0), '1);
		load_price('1, '1);
		load_price(IDX_W'(ROD_MAX + 1), PVAL_W'(1234));
		// top price on length 1: clamped solve gives 64 pieces at peak revenue
		load_price(IDX_W'(1), '1);
		solve_rod('1);
		load_price(IDX_W'(ROD_MAX), PVAL_W'(40000));
		// textbook price list; length 8 has a tie between cuts 2 and 6
		load_price(IDX_W'(1), PVAL_W'(1));
		load_price(IDX_W'(2), PVAL_W'(5));
		load_price(IDX_W'(3), PVAL_W'(8));
		load_price(IDX_W'(4), PVAL_W'(9));
		load_price(IDX_W'(5), PVAL_W'(10));
		load_price(IDX_W'(6), PVAL_W'(17));
		load_price(IDX_W'(7), PVAL_W'(17));
		load_price(IDX_W'(8), PVAL_W'(20));
		solve_rod(RLEN_W'(4));
		solve_rod(RLEN_W'(8));
		solve_rod(RLEN_W'(7));
		load_price(IDX_W'(1), '0);
		solve_rod(RLEN_W'(1));
		solve_rod(RLEN_W'(ROD_MAX));
		solve_rod(RLEN_W'(0));

		// hold the input until every planned piece has come out
		drain_results();

		for (step = 0; step < RANDOM_ITEMS; step++) begin
			stall_free = (step >= 45 && step < 75);
			if ($urandom_range(99) < 62)
				load_price(pick_index(), pick_price());
			else
				solve_rod(pick_length());
			if (step == 80)
				drain_results();
		end
		stall_free = 1'b0;

		drain_results();
		repeat (100) @(negedge clk);

		$display("%0d input beats, %0d solves, %0d pieces checked, %0d still planned",
			beats_sent, sb.solves, sb.pieces_checked, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("rod_cutting_dp_tb passed");
		else
			$display("rod_cutting_dp_tb failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/rcd_pkg.sv
rtl/core/rcd_price_mem.sv
rtl/core/rcd_dp_mem.sv
rtl/core/rcd_solver.sv
rtl/core/rod_cutting_dp.sv
verif/rod_cutting_dp_tb.sv
